>>> src/accumulator_machine_execute_defines.svh
// assertion macros shared by the execute unit modules
`ifndef ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define AME_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ame_pkg.sv
package ame_pkg;

   // machine geometry
   localparam int MEM_WORDS = 100;
   localparam int WORD_BITS = 16;
   localparam int ADDR_BITS = 7;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   localparam logic [ADDR_BITS-1:0] HALT_PC  = ADDR_BITS'(100);
   localparam logic [ADDR_BITS-1:0] MEM_TOP  = ADDR_BITS'(MEM_WORDS);
   localparam logic [CNT_BITS-1:0]  DIV_LAST = CNT_BITS'(WORD_BITS - 1);
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // operation codes
   typedef enum logic [3:0] {
      OP_READ   = 4'd0,
      OP_WRITE  = 4'd1,
      OP_LOAD   = 4'd2,
      OP_STORE  = 4'd3,
      OP_ADD    = 4'd4,
      OP_SUB    = 4'd5,
      OP_MUL    = 4'd6,
      OP_DIV    = 4'd7,
      OP_REM    = 4'd8,
      OP_BR     = 4'd9,
      OP_BRNEG  = 4'd10,
      OP_BRZERO = 4'd11,
      OP_HALT   = 4'd12
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_REM_ZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_DIVIDE = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_go;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

>>> src/ame_ctrl.sv
`include "accumulator_machine_execute_defines.svh"

module ame_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ame_pkg::stat_type stat,
   output ame_pkg::cmd_type  cmd
);

   ame_pkg::state_type state_ff;
   ame_pkg::state_type state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ame_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ame_pkg::S_EXEC;
            end
         end
         ame_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.div_go ? ame_pkg::S_DIVIDE : ame_pkg::S_DONE;
         end
         ame_pkg::S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ame_pkg::S_DONE;
            end
         end
         ame_pkg::S_DONE: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ame_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ame_pkg::S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ame_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `AME_ASSERT_NEXT(a_accept_to_exec, req_valid && req_ready, state_ff == ame_pkg::S_EXEC, "accepted transaction did not enter execute")
   `AME_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command at once")

endmodule

>>> src/ame_datapath.sv
`include "accumulator_machine_execute_defines.svh"

module ame_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ame_pkg::cmd_type                      cmd,
   output ame_pkg::stat_type                     stat,
   input  logic [3:0]                            req_op,
   input  logic [ame_pkg::ADDR_BITS-1:0]         req_address,
   input  logic signed [ame_pkg::WORD_BITS-1:0]  req_read_value,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [ame_pkg::WORD_BITS-1:0]  rsp_out_value,
   output logic                                  rsp_out_valid,
   output logic [1:0]                            rsp_status,
   output logic signed [ame_pkg::WORD_BITS-1:0]  rsp_acc_now,
   output logic [ame_pkg::ADDR_BITS-1:0]         rsp_next_pc,
   output logic                                  rsp_halted
);

   localparam int W = ame_pkg::WORD_BITS;
   localparam int A = ame_pkg::ADDR_BITS;

   // word memory
   logic [W-1:0] mem [ame_pkg::MEM_WORDS];
   logic [W-1:0] mem_q_ff;

   // architectural state
   logic [W-1:0] acc_ff;
   logic [A-1:0] pc_ff;

   // captured transaction
   logic [3:0]   op_ff;
   logic [A-1:0] addr_ff;
   logic [W-1:0] rv_ff;
   logic         in_range_ff;

   // execute results
   logic [W-1:0] acc_res_ff,   acc_res_in;
   logic [A-1:0] pc_res_ff,    pc_res_in;
   logic [1:0]   status_res_ff, status_res_in;
   logic [W-1:0] outv_res_ff,  outv_res_in;
   logic         outvld_res_ff, outvld_res_in;
   logic         halted_res_ff, halted_res_in;
   logic         we_res_ff,    we_res_in;
   logic [W-1:0] wdata_res_ff, wdata_res_in;
   logic         div_go;

   // divider
   logic [W-1:0]              dvd_ff;
   logic [W-1:0]              dvs_ff;
   logic [W-1:0]              rem_ff;
   logic [ame_pkg::CNT_BITS-1:0] cnt_ff;
   logic                      neg_q_ff;
   logic                      neg_r_ff;
   logic                      is_rem_ff;
   logic                      div_used_ff;
   logic [W:0]                r_shift;
   logic [W:0]                r_diff;

   // output register
   logic         rsp_valid_ff;
   logic [W-1:0] rsp_out_value_ff;
   logic         rsp_out_valid_ff;
   logic [1:0]   rsp_status_ff;
   logic [W-1:0] rsp_acc_now_ff;
   logic [A-1:0] rsp_next_pc_ff;
   logic         rsp_halted_ff;

   logic [W-1:0]   m_word;
   logic [2*W-1:0] prod;
   logic [W-1:0]   acc_abs;
   logic [W-1:0]   m_abs;
   logic [A-1:0]   pc_inc;
   logic [W-1:0]   q_fix;
   logic [W-1:0]   r_fix;
   logic [W-1:0]   acc_final;

   // memory port: one read at capture, one write at commit
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mem_q_ff <= mem[req_address];
      end
      if (cmd.commit && we_res_ff && in_range_ff) begin
         mem[addr_ff] <= wdata_res_ff;
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_op;
         addr_ff     <= req_address;
         rv_ff       <= req_read_value;
         in_range_ff <= (req_address < ame_pkg::MEM_TOP);
      end
   end

   // operand and arithmetic
   assign m_word  = in_range_ff ? mem_q_ff : '0;
   assign prod    = acc_ff * m_word;
   assign acc_abs = acc_ff[W-1] ? W'(~acc_ff + W'(1)) : acc_ff;
   assign m_abs   = m_word[W-1] ? W'(~m_word + W'(1)) : m_word;
   assign pc_inc  = A'(pc_ff + A'(1));

   // instruction decode and execute
   always_comb begin
      acc_res_in    = acc_ff;
      pc_res_in     = pc_inc;
      status_res_in = ame_pkg::ST_OK;
      outv_res_in   = '0;
      outvld_res_in = 1'b0;
      halted_res_in = 1'b0;
      we_res_in     = 1'b0;
      wdata_res_in  = rv_ff;
      div_go        = 1'b0;
      unique case (op_ff) inside
         ame_pkg::OP_READ: begin
            we_res_in = 1'b1;
         end
         ame_pkg::OP_WRITE: begin
            outv_res_in   = m_word;
            outvld_res_in = 1'b1;
         end
         ame_pkg::OP_LOAD: begin
            acc_res_in = m_word;
         end
         ame_pkg::OP_STORE: begin
            we_res_in    = 1'b1;
            wdata_res_in = acc_ff;
         end
         ame_pkg::OP_ADD: begin
            acc_res_in = W'(acc_ff + m_word);
         end
         ame_pkg::OP_SUB: begin
            acc_res_in = W'(acc_ff - m_word);
         end
         ame_pkg::OP_MUL: begin
            acc_res_in = prod[W-1:0];
         end
         ame_pkg::OP_DIV, ame_pkg::OP_REM: begin
            if (m_word == '0) begin
               status_res_in = (op_ff == ame_pkg::OP_DIV) ? ame_pkg::ST_DIV_ZERO
                                                          : ame_pkg::ST_REM_ZERO;
               pc_res_in     = pc_ff;
            end else if (acc_ff == ame_pkg::WORD_MIN && m_word == '1) begin
               status_res_in = ame_pkg::ST_OVERFLOW;
               pc_res_in     = pc_ff;
            end else begin
               div_go = 1'b1;
            end
         end
         ame_pkg::OP_BR: begin
            pc_res_in = addr_ff;
         end
         ame_pkg::OP_BRNEG: begin
            if (acc_ff[W-1]) begin
               pc_res_in = addr_ff;
            end
         end
         ame_pkg::OP_BRZERO: begin
            if (acc_ff == '0) begin
               pc_res_in = addr_ff;
            end
         end
         ame_pkg::OP_HALT: begin
            pc_res_in     = ame_pkg::HALT_PC;
            halted_res_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // execute result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         acc_res_ff    <= acc_res_in;
         pc_res_ff     <= pc_res_in;
         status_res_ff <= status_res_in;
         outv_res_ff   <= outv_res_in;
         outvld_res_ff <= outvld_res_in;
         halted_res_ff <= halted_res_in;
         we_res_ff     <= we_res_in;
         wdata_res_ff  <= wdata_res_in;
         div_used_ff   <= div_go;
      end
   end

   // restoring divider step on magnitudes
   assign r_shift = {1'b0, rem_ff[W-2:0], dvd_ff[W-1]} | {rem_ff[W-1], {W{1'b0}}};
   assign r_diff  = r_shift - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         dvd_ff    <= acc_abs;
         dvs_ff    <= m_abs;
         rem_ff    <= '0;
         cnt_ff    <= '0;
         neg_q_ff  <= acc_ff[W-1] ^ m_word[W-1];
         neg_r_ff  <= acc_ff[W-1];
         is_rem_ff <= (op_ff == ame_pkg::OP_REM);
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[W-2:0], ~r_diff[W]};
         rem_ff <= r_diff[W] ? r_shift[W-1:0] : r_diff[W-1:0];
         cnt_ff <= ame_pkg::CNT_BITS'(cnt_ff + 1'b1);
      end
   end

   // sign correction of quotient and remainder
   assign q_fix     = neg_q_ff ? W'(~dvd_ff + W'(1)) : dvd_ff;
   assign r_fix     = neg_r_ff ? W'(~rem_ff + W'(1)) : rem_ff;
   assign acc_final = div_used_ff ? (is_rem_ff ? r_fix : q_fix) : acc_res_ff;

   // controller status
   assign stat.div_go   = div_go;
   assign stat.div_last = (cnt_ff == ame_pkg::DIV_LAST);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // architectural state update
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pc_ff  <= '0;
      end else if (cmd.commit) begin
         acc_ff <= acc_final;
         pc_ff  <= pc_res_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_out_value_ff <= outv_res_ff;
         rsp_out_valid_ff <= outvld_res_ff;
         rsp_status_ff    <= status_res_ff;
         rsp_acc_now_ff   <= acc_final;
         rsp_next_pc_ff   <= pc_res_ff;
         rsp_halted_ff    <= halted_res_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_out_value_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_acc_now   = rsp_acc_now_ff;
   assign rsp_next_pc   = rsp_next_pc_ff;
   assign rsp_halted    = rsp_halted_ff;

   // checks
   `AME_ASSERT_NOW(a_commit_free, cmd.commit, !rsp_valid_ff || rsp_ready, "result overwritten before taken")
   `AME_ASSERT_NOW(a_rem_below_dvs, cmd.div_step, rem_ff < dvs_ff, "divider remainder not below divisor")
   `AME_ASSERT_NOW(a_fault_holds_pc, cmd.commit && status_res_ff != ame_pkg::ST_OK, pc_res_ff == pc_ff, "faulting divide moved the program counter")

endmodule

>>> src/accumulator_machine_execute.sv
// accumulator machine execute unit, one instruction per transaction
// sequence: accept, then the execute state, the divider state for divide and remainder
// (16-step restoring divider), then the done state, which commits to the output register;
// a new instruction is taken only after commit; an untaken result stalls the next commit
// reset: synchronous active high; clears accumulator, pc and handshake state, memory unset

module accumulator_machine_execute (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [3:0]                            req_op,
   input  logic [ame_pkg::ADDR_BITS-1:0]         req_address,
   input  logic signed [ame_pkg::WORD_BITS-1:0]  req_read_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ame_pkg::WORD_BITS-1:0]  rsp_out_value,
   output logic                                  rsp_out_valid,
   output logic [1:0]                            rsp_status,
   output logic signed [ame_pkg::WORD_BITS-1:0]  rsp_acc_now,
   output logic [ame_pkg::ADDR_BITS-1:0]         rsp_next_pc,
   output logic                                  rsp_halted
);

   ame_pkg::cmd_type  cmd;
   ame_pkg::stat_type stat;

   // sequencer
   ame_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // memory, accumulator, divider and result register
   ame_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_op),
      .req_address    (req_address),
      .req_read_value (req_read_value),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_status     (rsp_status),
      .rsp_acc_now    (rsp_acc_now),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_halted     (rsp_halted)
   );

endmodule
